/* design/line_rasterizer_macros.svh */
// assertion macros shared by the line rasterizer rtl
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

// property that must hold on every clock edge outside reset
`define LR_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when the antecedent holds, the consequent must hold in the following cycle
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/lr_pkg.sv */
// shared constants and helpers for the line rasterizer
package lr_pkg;

    // default coordinate width
    localparam int LR_COORD_BITS = 11;

    // beat kind carried on the input tuser
    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_STEP = 1'b1
    } t_func;

    // round a bit count up to whole bytes
    function automatic int lr_byte_round(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

/* design/line_rasterizer.sv */
// line rasterizer top level: bresenham line engine, one pixel per step beat
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata: x_start y_start x_end y_end color
//                                                 tuser: func (0 load, 1 step)
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata: pixel_x pixel_y pixel_address
//                                                 pixel_color, tlast: last
//  cfg       in   i_cfg_wr_en                     i_cfg_wr_data: row_stride
//
// every accepted beat is handled in the cycle it is taken: one beat per clock
// sustained while m_axis does not stall, a pixel appears on m_axis in the cycle after its step beat
// the critical path is the row * stride multiply plus the column add
// a load beat and a step while no line is active produce no output beat
// reset (synchronous, active low) drops the active line and sets the stride to
// 2048, which fits the 12-bit stride register as it is
// s_axis_tready is high while the output register is empty or being drained,
// so a stalled m_axis holds one pixel and back-pressures the input
`include "line_rasterizer_macros.svh"

module line_rasterizer
    import lr_pkg::*;
#(
    parameter int COORD_BITS = LR_COORD_BITS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    // configuration write
    input  logic                                          i_cfg_wr_en,
    input  logic [COORD_BITS:0]                           i_cfg_wr_data, // row_stride
    // input stream
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // from bit 0: x_start, y_start, x_end, y_end, color, zero fill
    input  logic [lr_byte_round(4*COORD_BITS+32)-1:0]     s_axis_tdata,
    input  logic                                          s_axis_tuser,  // func
    // output stream
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // from bit 0: pixel_x, pixel_y, pixel_address, pixel_color, zero fill
    output logic [lr_byte_round(4*COORD_BITS+32)-1:0]     m_axis_tdata,
    output logic                                          m_axis_tlast   // last
);

    localparam int CW = COORD_BITS;          // coordinate width
    localparam int SW = COORD_BITS + 1;      // row stride width
    localparam int AW = 2 * COORD_BITS;      // address width
    localparam int EW = COORD_BITS + 2;      // error term width
    localparam int XW = COORD_BITS + 3;      // doubled error term width
    localparam int DW = lr_byte_round(4*COORD_BITS+32);

    // tdata field offsets, input side
    localparam int XS_LO  = 0;
    localparam int YS_LO  = CW;
    localparam int XE_LO  = 2 * CW;
    localparam int YE_LO  = 3 * CW;
    localparam int COL_LO = 4 * CW;
    // tdata field offsets, output side
    localparam int PX_LO  = 0;
    localparam int PY_LO  = CW;
    localparam int PA_LO  = 2 * CW;
    localparam int PC_LO  = 2 * CW + AW;

    // stride reset is 2^COORD_BITS truncated to the register width
    localparam logic [SW-1:0] STRIDE_RST = SW'(2**COORD_BITS);

    // line state
    logic [CW-1:0] r_cur_x,  n_cur_x;
    logic [CW-1:0] r_cur_y,  n_cur_y;
    logic [CW-1:0] r_goal_x, n_goal_x;
    logic [CW-1:0] r_goal_y, n_goal_y;
    logic [CW-1:0] r_span_x, n_span_x;
    logic [CW-1:0] r_span_y, n_span_y;
    logic [EW-1:0] r_err,    n_err;
    logic          r_dir_x_neg, n_dir_x_neg;
    logic          r_dir_y_neg, n_dir_y_neg;
    logic [31:0]   r_color,  n_color;
    logic          r_busy,   n_busy;
    logic [SW-1:0] r_row_stride;

    // output register
    logic          r_out_valid, n_out_valid;
    logic [DW-1:0] r_out_data,  n_out_data;
    logic          r_out_last,  n_out_last;

    // input beat fields
    logic [CW-1:0] in_xs, in_ys, in_xe, in_ye;
    logic [31:0]   in_color;
    logic          in_acc;
    logic          is_step;

    // step datapath
    logic              at_end;
    logic signed [XW-1:0] e2;
    logic signed [XW-1:0] span_x_s, span_y_s;
    logic              move_x, move_y;
    logic [XW-1:0]     err_upd;
    logic [AW:0]       row_base;
    logic [AW:0]       addr_sum;

    assign in_xs    = s_axis_tdata[XS_LO  +: CW];
    assign in_ys    = s_axis_tdata[YS_LO  +: CW];
    assign in_xe    = s_axis_tdata[XE_LO  +: CW];
    assign in_ye    = s_axis_tdata[YE_LO  +: CW];
    assign in_color = s_axis_tdata[COL_LO +: 32];

    // skid-free: accept whenever the output register is free or drains now
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_step       = (s_axis_tuser == FUNC_STEP);

    // bresenham decision on the current error term
    assign at_end   = (r_cur_x == r_goal_x) && (r_cur_y == r_goal_y);
    assign e2       = $signed({r_err, 1'b0});
    assign span_x_s = $signed({2'b00, r_span_x, 1'b0} >> 1);
    assign span_y_s = $signed({2'b00, r_span_y, 1'b0} >> 1);
    assign move_x   = e2 > -span_y_s;
    assign move_y   = e2 < span_x_s;
    assign err_upd  = {r_err[EW-1], r_err}
                      - (move_x ? XW'(r_span_y) : XW'(0))
                      + (move_y ? XW'(r_span_x) : XW'(0));

    // framebuffer address, wraps to the address width
    assign row_base = r_cur_y * r_row_stride;
    assign addr_sum = row_base + (AW+1)'(r_cur_x);

    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_goal_x    = r_goal_x;
        n_goal_y    = r_goal_y;
        n_span_x    = r_span_x;
        n_span_y    = r_span_y;
        n_err       = r_err;
        n_dir_x_neg = r_dir_x_neg;
        n_dir_y_neg = r_dir_y_neg;
        n_color     = r_color;
        n_busy      = r_busy;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;

        if (in_acc) begin
            if (!is_step) begin
                // load replaces any active line
                n_cur_x     = in_xs;
                n_cur_y     = in_ys;
                n_goal_x    = in_xe;
                n_goal_y    = in_ye;
                n_dir_x_neg = in_xe < in_xs;
                n_dir_y_neg = in_ye < in_ys;
                n_span_x    = (in_xe < in_xs) ? in_xs - in_xe : in_xe - in_xs;
                n_span_y    = (in_ye < in_ys) ? in_ys - in_ye : in_ye - in_ys;
                n_err       = {2'b00, n_span_x} - {2'b00, n_span_y};
                n_color     = in_color;
                n_busy      = 1'b1;
            end else if (r_busy) begin
                // emit the current pixel
                n_out_valid              = 1'b1;
                n_out_data               = '0;
                n_out_data[PX_LO +: CW]  = r_cur_x;
                n_out_data[PY_LO +: CW]  = r_cur_y;
                n_out_data[PA_LO +: AW]  = addr_sum[AW-1:0];
                n_out_data[PC_LO +: 32]  = r_color;
                n_out_last               = at_end;
                if (at_end) begin
                    n_busy = 1'b0;
                end else begin
                    n_err = err_upd[EW-1:0];
                    if (move_x) begin
                        n_cur_x = r_dir_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                    end
                    if (move_y) begin
                        n_cur_y = r_dir_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_goal_x     <= '0;
            r_goal_y     <= '0;
            r_span_x     <= '0;
            r_span_y     <= '0;
            r_err        <= '0;
            r_dir_x_neg  <= 1'b0;
            r_dir_y_neg  <= 1'b0;
            r_color      <= '0;
            r_busy       <= 1'b0;
            r_row_stride <= STRIDE_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_goal_x    <= n_goal_x;
            r_goal_y    <= n_goal_y;
            r_span_x    <= n_span_x;
            r_span_y    <= n_span_y;
            r_err       <= n_err;
            r_dir_x_neg <= n_dir_x_neg;
            r_dir_y_neg <= n_dir_y_neg;
            r_color     <= n_color;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_row_stride <= i_cfg_wr_data;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // a load beat arms the line and puts nothing on the output
    `LR_ASSERT_NEXT(a_load_no_out, i_clk, i_rst_n,
        in_acc && !is_step, r_busy && !r_out_valid,
        "load beat produced output or left engine idle")
    // a step with no active line puts nothing on the output
    `LR_ASSERT_NEXT(a_idle_step_no_out, i_clk, i_rst_n,
        in_acc && is_step && !r_busy, !r_out_valid && !r_busy,
        "idle step produced output")
    // the end point is flagged last and closes the line
    `LR_ASSERT_NEXT(a_end_closes, i_clk, i_rst_n,
        in_acc && is_step && r_busy && at_end, r_out_valid && r_out_last && !r_busy,
        "end point did not close the line")
    // a step short of the end point moves the pen
    `LR_ASSERT_NEXT(a_step_moves, i_clk, i_rst_n,
        in_acc && is_step && r_busy && !at_end,
        (r_cur_x != $past(r_cur_x)) || (r_cur_y != $past(r_cur_y)),
        "step did not advance the pen")

endmodule
